// ===== hdl/rrt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rrt_pkg;

	localparam int ID_W     = 9;
	localparam int CNT_W    = 8;
	localparam int SEQ_W    = 32;
	localparam int OP_W     = 3;
	localparam int REG_W    = 5;
	localparam int CFG_IDX_W = 1;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 88;

	localparam logic [OP_W-1:0] OP_MAP_INT   = 3'd0;
	localparam logic [OP_W-1:0] OP_MAP_FP    = 3'd1;
	localparam logic [OP_W-1:0] OP_ALLOC_INT = 3'd2;
	localparam logic [OP_W-1:0] OP_ALLOC_FP  = 3'd3;
	localparam logic [OP_W-1:0] OP_FREE_INT  = 3'd4;
	localparam logic [OP_W-1:0] OP_FREE_FP   = 3'd5;
	localparam logic [OP_W-1:0] OP_FLUSH     = 3'd6;

	localparam logic [CFG_IDX_W-1:0] CFG_INT_TOTAL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FP_TOTAL  = 1'b1;

	localparam logic [ID_W-1:0] CFG_TOTAL_RST = 9'd128;

	typedef struct packed {
		logic            flush;
		logic            pop;
		logic            push;
		logic [ID_W-1:0] id;
	} stk_cmd_t;

	typedef struct packed {
		logic             empty;
		logic [CNT_W-1:0] level;
		logic [CNT_W-1:0] pending;
	} stk_stat_t;

	typedef struct packed {
		logic            flush;
		logic            we;
		logic [ID_W-1:0] data;
	} map_wr_t;

endpackage
`default_nettype wire

// ===== hdl/rrt_rename_map.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rrt_rename_map import rrt_pkg::*; #(
	parameter int ARCH_REGS = 32
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   rd_en,
	input  wire  [REG_W-1:0]      rd_reg,
	input  wire  map_wr_t         wr,
	output logic [ID_W-1:0]       rd_id
);

	localparam int AW = (ARCH_REGS > 1) ? $clog2(ARCH_REGS) : 1;

	logic [ID_W-1:0]      mem [ARCH_REGS];
	logic [ARCH_REGS-1:0] vld_q;
	logic [ID_W-1:0]      rdata_s1;
	logic                 hit_s1;
	logic [AW-1:0]        idx_s1;
	logic [AW-1:0]        rd_idx;

	assign rd_idx = AW'(rd_reg);

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[idx_s1] <= wr.data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			hit_s1 <= 1'b0;
			idx_s1 <= '0;
		end else begin
			if (wr.flush) begin
				vld_q <= '0;
			end else if (wr.we) begin
				vld_q[idx_s1] <= 1'b1;
			end
			if (rd_en) begin
				hit_s1 <= vld_q[rd_idx];
				idx_s1 <= rd_idx;
			end
		end
	end

	// an entry never written since flush holds its register number plus one
	assign rd_id = hit_s1 ? rdata_s1 : (ID_W'(idx_s1) + ID_W'(1));

endmodule
`default_nettype wire

// ===== hdl/rrt_free_stack.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rrt_free_stack import rrt_pkg::*; #(
	parameter int ARCH_REGS = 32,
	parameter int DEPTH     = 224
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire  [ID_W-1:0]       total,
	input  wire                   rd_en,
	input  wire  stk_cmd_t        cmd,
	output logic [ID_W-1:0]       top_id,
	output stk_stat_t             stat
);

	localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW = $clog2(DEPTH + 1);

	function automatic logic [LW-1:0] cap_f(input logic [ID_W-1:0] tot);
		logic [31:0] diff;
		diff = 32'(tot) - 32'(ARCH_REGS);
		if (32'(tot) <= 32'(ARCH_REGS)) begin
			return '0;
		end else if (diff >= 32'(DEPTH)) begin
			return LW'(DEPTH);
		end else begin
			return LW'(diff);
		end
	endfunction

	logic [ID_W-1:0] mem [DEPTH];
	logic [LW-1:0]   level_q;
	logic [LW-1:0]   low_q;
	logic [LW-1:0]   pending_q;
	logic [ID_W-1:0] rdata_s1;
	logic            hit_s1;
	logic [SW-1:0]   addr_s1;
	logic [LW-1:0]   level_dn;
	logic            room;

	assign level_dn = level_q - LW'(1);
	assign room     = (32'(level_q) < 32'(DEPTH));

	always_ff @(posedge clk) begin
		if (cmd.push && room) begin
			mem[SW'(level_q)] <= cmd.id;
		end
		if (rd_en) begin
			rdata_s1 <= mem[SW'(level_dn)];
		end
	end

	// entries at or above the lowest level since flush were pushed since flush
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q   <= cap_f(CFG_TOTAL_RST);
			low_q     <= cap_f(CFG_TOTAL_RST);
			pending_q <= '0;
			hit_s1    <= 1'b0;
			addr_s1   <= '0;
		end else begin
			priority if (cmd.flush) begin
				level_q   <= cap_f(total);
				low_q     <= cap_f(total);
				pending_q <= '0;
			end else if (cmd.pop) begin
				level_q   <= level_dn;
				pending_q <= pending_q + LW'(1);
				if (level_dn < low_q) begin
					low_q <= level_dn;
				end
			end else if (cmd.push) begin
				if (room) begin
					level_q <= level_q + LW'(1);
				end
				pending_q <= (pending_q != '0) ? pending_q - LW'(1) : '0;
			end
			if (rd_en) begin
				hit_s1  <= (level_q > low_q);
				addr_s1 <= SW'(level_dn);
			end
		end
	end

	assign top_id       = hit_s1 ? rdata_s1 : (ID_W'(ARCH_REGS + 1) + ID_W'(addr_s1));
	assign stat.empty   = (level_q == '0);
	assign stat.level   = CNT_W'(level_q);
	assign stat.pending = CNT_W'(pending_q);

endmodule
`default_nettype wire

// ===== hdl/register_rename_table.sv =====
// the item and its reads are registered, then the result once the output is free
// one item at a time, set by the read-then-write pass over the map and
//   stack memories; a new item is taken while the previous result still waits
// flush rebuilds maps and stacks with no clearing pass
// asynchronous active-low reset restores maps, stacks, counters and both totals (128)
`timescale 1ns / 1ps
`default_nettype none
module register_rename_table import rrt_pkg::*; #(
	parameter int ARCH_REGS      = 32,
	parameter int INT_FREE_DEPTH = 224,
	parameter int FP_FREE_DEPTH  = 224
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_valid,
	output logic                   cfg_ready,
	input  wire  [CFG_IDX_W-1:0]   cfg_index,
	input  wire  [ID_W-1:0]        cfg_data,
	input  wire                    s_tvalid,
	output logic                   s_tready,
	// areg, freed_phys, restore_phys
	input  wire  [S_TDATA_W-1:0]   s_tdata,
	// opcode
	input  wire  [OP_W-1:0]        s_tuser,
	output logic                   m_tvalid,
	input  wire                    m_tready,
	// phys_id, prior_phys, int_free_left, fp_free_left, int_in_flight, fp_in_flight,
	// int_sequence
	output logic [M_TDATA_W-1:0]   m_tdata,
	// success
	output logic                   m_tuser
);

	logic [ID_W-1:0]  int_total_q;
	logic [ID_W-1:0]  fp_total_q;
	logic             busy_q;
	logic [OP_W-1:0]  op_s1;
	logic [REG_W-1:0] reg_s1;
	logic [ID_W-1:0]  freed_s1;
	logic [ID_W-1:0]  restore_s1;
	logic             m_valid_q;
	logic [ID_W-1:0]  phys_q;
	logic [ID_W-1:0]  prior_q;
	logic             ok_q;
	logic [SEQ_W-1:0] seq_q;

	logic             accept;
	logic             fire;
	logic             reg_in;
	logic             reg_nz;
	logic             int_alloc_ok;
	logic             fp_alloc_ok;
	logic             int_free_ok;
	logic             fp_free_ok;
	logic             do_flush;
	logic [ID_W-1:0]  int_map_id;
	logic [ID_W-1:0]  fp_map_id;
	logic [ID_W-1:0]  int_top;
	logic [ID_W-1:0]  fp_top;
	logic [ID_W-1:0]  phys_d;
	logic [ID_W-1:0]  prior_d;
	stk_stat_t        int_stat;
	stk_stat_t        fp_stat;
	stk_cmd_t         int_cmd;
	stk_cmd_t         fp_cmd;
	map_wr_t          int_wr;
	map_wr_t          fp_wr;

	assign cfg_ready = 1'b1;
	assign s_tready  = !busy_q;
	assign accept    = s_tvalid && s_tready;
	assign fire      = busy_q && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_total_q <= CFG_TOTAL_RST;
			fp_total_q  <= CFG_TOTAL_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_INT_TOTAL: int_total_q <= cfg_data;
				CFG_FP_TOTAL:  fp_total_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= s_tuser;
			reg_s1     <= s_tdata[4:0];
			freed_s1   <= s_tdata[13:5];
			restore_s1 <= s_tdata[22:14];
		end
	end

	assign reg_in       = (32'(reg_s1) < 32'(ARCH_REGS));
	assign reg_nz       = (reg_s1 != '0);
	assign int_alloc_ok = (op_s1 == OP_ALLOC_INT) && reg_in && reg_nz && !int_stat.empty;
	assign fp_alloc_ok  = (op_s1 == OP_ALLOC_FP) && reg_in && !fp_stat.empty;
	assign int_free_ok  = (op_s1 == OP_FREE_INT) && reg_in && reg_nz && (freed_s1 != '0);
	assign fp_free_ok   = (op_s1 == OP_FREE_FP) && reg_in && (freed_s1 != '0);
	assign do_flush     = (op_s1 == OP_FLUSH);

	assign int_cmd.flush = fire && do_flush;
	assign int_cmd.pop   = fire && int_alloc_ok;
	assign int_cmd.push  = fire && int_free_ok;
	assign int_cmd.id    = freed_s1;
	assign fp_cmd.flush  = fire && do_flush;
	assign fp_cmd.pop    = fire && fp_alloc_ok;
	assign fp_cmd.push   = fire && fp_free_ok;
	assign fp_cmd.id     = freed_s1;

	assign int_wr.flush = fire && do_flush;
	assign int_wr.we    = fire && (int_alloc_ok || int_free_ok);
	assign int_wr.data  = int_alloc_ok ? int_top : restore_s1;
	assign fp_wr.flush  = fire && do_flush;
	assign fp_wr.we     = fire && (fp_alloc_ok || fp_free_ok);
	assign fp_wr.data   = fp_alloc_ok ? fp_top : restore_s1;

	rrt_rename_map #(.ARCH_REGS(ARCH_REGS)) u_int_map (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.rd_reg (s_tdata[4:0]),
		.wr     (int_wr),
		.rd_id  (int_map_id)
	);

	rrt_rename_map #(.ARCH_REGS(ARCH_REGS)) u_fp_map (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.rd_reg (s_tdata[4:0]),
		.wr     (fp_wr),
		.rd_id  (fp_map_id)
	);

	rrt_free_stack #(.ARCH_REGS(ARCH_REGS), .DEPTH(INT_FREE_DEPTH)) u_int_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.total  (int_total_q),
		.rd_en  (accept),
		.cmd    (int_cmd),
		.top_id (int_top),
		.stat   (int_stat)
	);

	rrt_free_stack #(.ARCH_REGS(ARCH_REGS), .DEPTH(FP_FREE_DEPTH)) u_fp_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.total  (fp_total_q),
		.rd_en  (accept),
		.cmd    (fp_cmd),
		.top_id (fp_top),
		.stat   (fp_stat)
	);

	always_comb begin
		phys_d  = '0;
		prior_d = '0;
		unique case (op_s1)
			OP_MAP_INT: phys_d = reg_in ? int_map_id : '0;
			OP_MAP_FP:  phys_d = reg_in ? fp_map_id : '0;
			OP_ALLOC_INT: begin
				phys_d  = int_alloc_ok ? int_top : '0;
				prior_d = int_alloc_ok ? int_map_id : '0;
			end
			OP_ALLOC_FP: begin
				phys_d  = fp_alloc_ok ? fp_top : '0;
				prior_d = fp_alloc_ok ? fp_map_id : '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			phys_q  <= phys_d;
			prior_q <= prior_d;
			ok_q    <= int_alloc_ok || fp_alloc_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			m_valid_q <= 1'b0;
			seq_q     <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (fire) begin
				busy_q <= 1'b0;
			end
			if (fire) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (fire && (int_alloc_ok || int_free_ok)) begin
				seq_q <= seq_q + SEQ_W'(1);
			end
		end
	end

	// counts change only when the next item completes, after this one is taken
	assign m_tvalid = m_valid_q;
	assign m_tuser  = ok_q;
	assign m_tdata  = {6'b0, seq_q, fp_stat.pending, int_stat.pending,
		fp_stat.level, int_stat.level, prior_q, phys_q};

endmodule
`default_nettype wire

// ===== hdl/rrt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rrt_checker import rrt_pkg::*; (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  s_tvalid,
	input wire                  s_tready,
	input wire                  m_tvalid,
	input wire                  m_tready,
	input wire [M_TDATA_W-1:0]  m_tdata,
	input wire                  m_tuser
);

	// one item in the read-modify-write pass at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted while previous one still in progress");

	a_result_timing: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |-> ##2 m_tvalid)
		else $error("result not offered two cycles after item");

	a_prior_only_on_success: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[17:9] == '0)
		else $error("replaced id reported without a successful alloc");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind register_rename_table rrt_checker u_rrt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

// ===== verif/tb_register_rename_table.sv =====
`timescale 1ns / 1ps
module tb_register_rename_table;
	import rrt_pkg::*;

	localparam int ARCH  = 32;
	localparam int DEPTH = 224;
	localparam int OUT_BITS = SEQ_W + 4 * CNT_W + 2 * ID_W;

	// one result item, success on top, then m_tdata fields from the highest down
	typedef struct packed {
		logic             success;
		logic [SEQ_W-1:0] int_sequence;
		logic [CNT_W-1:0] fp_in_flight;
		logic [CNT_W-1:0] int_in_flight;
		logic [CNT_W-1:0] fp_free_left;
		logic [CNT_W-1:0] int_free_left;
		logic [ID_W-1:0]  prior_phys;
		logic [ID_W-1:0]  phys_id;
	} rename_exp_t;

	// an allocation not yet given back, used to build well-formed frees
	typedef struct {
		logic [REG_W-1:0] areg;
		logic [ID_W-1:0]  new_id;
		logic [ID_W-1:0]  old_id;
	} rename_tag_t;

	class rename_scoreboard;
		logic [ID_W-1:0] alias_map [2][ARCH];
		logic [ID_W-1:0] free_ids [2][DEPTH];
		int              free_cnt [2];
		int              live_cnt [2];
		int              total_cfg [2];
		logic [SEQ_W-1:0] int_ops;
		rename_exp_t     expected [$];
		int              failures;

		function new();
			total_cfg[0] = 128;
			total_cfg[1] = 128;
			int_ops = '0;
			failures = 0;
			rebuild(0);
			rebuild(1);
		endfunction

		function void rebuild(int c);
			int cap;
			for (int i = 0; i < ARCH; i++)
				alias_map[c][i] = ID_W'(i + 1);
			for (int i = 0; i < DEPTH; i++)
				free_ids[c][i] = ID_W'(ARCH + 1 + i);
			live_cnt[c] = 0;
			if (total_cfg[c] <= ARCH) begin
				cap = 0;
			end else begin
				cap = total_cfg[c] - ARCH;
				if (cap > DEPTH)
					cap = DEPTH;
			end
			free_cnt[c] = cap;
		endfunction

		function void set_total(logic [CFG_IDX_W-1:0] idx, logic [ID_W-1:0] val);
			total_cfg[idx] = int'(val);
		endfunction

		function rename_exp_t note_item(logic [OP_W-1:0] op, logic [REG_W-1:0] areg,
				logic [ID_W-1:0] freed, logic [ID_W-1:0] restore);
			rename_exp_t r;
			int c;
			r = '0;
			case (op)
				OP_MAP_INT, OP_MAP_FP: begin
					c = (op == OP_MAP_FP);
					if (areg < ARCH)
						r.phys_id = alias_map[c][areg];
				end
				OP_ALLOC_INT, OP_ALLOC_FP: begin
					c = (op == OP_ALLOC_FP);
					if (!(c == 0 && areg == 0) && areg < ARCH && free_cnt[c] != 0) begin
						r.prior_phys = alias_map[c][areg];
						free_cnt[c]--;
						r.phys_id = free_ids[c][free_cnt[c]];
						alias_map[c][areg] = r.phys_id;
						live_cnt[c]++;
						r.success = 1'b1;
						if (c == 0)
							int_ops++;
					end
				end
				OP_FREE_INT, OP_FREE_FP: begin
					c = (op == OP_FREE_FP);
					if (!(c == 0 && areg == 0) && areg < ARCH && freed != 0) begin
						alias_map[c][areg] = restore;
						// full stack drops the push but still rewinds the map
						if (free_cnt[c] < DEPTH) begin
							free_ids[c][free_cnt[c]] = freed;
							free_cnt[c]++;
						end
						if (live_cnt[c] > 0)
							live_cnt[c]--;
						if (c == 0)
							int_ops++;
					end
				end
				OP_FLUSH: begin
					rebuild(0);
					rebuild(1);
				end
				default: ;
			endcase
			r.int_free_left = CNT_W'(free_cnt[0]);
			r.fp_free_left  = CNT_W'(free_cnt[1]);
			r.int_in_flight = CNT_W'(live_cnt[0]);
			r.fp_in_flight  = CNT_W'(live_cnt[1]);
			r.int_sequence  = int_ops;
			expected.push_back(r);
			return r;
		endfunction

		function void compare_field(string name, logic [31:0] e, logic [31:0] a);
			if (e !== a) begin
				$error("%s mismatch: expected %0d, actual %0d", name, e, a);
				failures++;
			end
		endfunction

		function void check_result(rename_exp_t got);
			rename_exp_t e;
			if (expected.size() == 0) begin
				$error("result item with nothing outstanding");
				failures++;
				return;
			end
			e = expected.pop_front();
			compare_field("phys_id", e.phys_id, got.phys_id);
			compare_field("prior_phys", e.prior_phys, got.prior_phys);
			compare_field("success", e.success, got.success);
			compare_field("int_free_left", e.int_free_left, got.int_free_left);
			compare_field("fp_free_left", e.fp_free_left, got.fp_free_left);
			compare_field("int_in_flight", e.int_in_flight, got.int_in_flight);
			compare_field("fp_in_flight", e.fp_in_flight, got.fp_in_flight);
			compare_field("int_sequence", e.int_sequence, got.int_sequence);
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [ID_W-1:0]      cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [OP_W-1:0]      s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tuser;

	rename_scoreboard sb = new();
	rename_exp_t      last_pred;
	rename_tag_t      in_use [2][$];
	int               burst_left = 0;
	bit               hold_req = 1'b0;

	register_rename_table #(
		.ARCH_REGS(ARCH),
		.INT_FREE_DEPTH(DEPTH),
		.FP_FREE_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5000000;
		$display("Simulation FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result({m_tuser, m_tdata[OUT_BITS-1:0]});
	end

	// receiver: stretches of differing stall patterns, plus a long hold-off on request
	initial begin
		int mode;
		int left;
		mode = 0;
		left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (150) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(10, 80);
				end
				left--;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= (left % 3 == 0);
					default: m_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	task automatic pace();
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
	endtask

	task automatic send_op(logic [OP_W-1:0] op, logic [REG_W-1:0] areg,
			logic [ID_W-1:0] freed, logic [ID_W-1:0] restore);
		pace();
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {1'b0, restore, freed, areg};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		last_pred = sb.note_item(op, areg, freed, restore);
		if (op == OP_FLUSH) begin
			in_use[0].delete();
			in_use[1].delete();
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ID_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_total(idx, val);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.expected.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic random_op(int alloc_bias);
		int r;
		int c;
		int k;
		rename_tag_t t;
		logic [REG_W-1:0] areg;
		r = $urandom_range(0, 99);
		c = $urandom_range(0, 1);
		if (r < 2) begin
			send_op(OP_FLUSH, REG_W'($urandom), ID_W'($urandom_range(0, 256)),
				ID_W'($urandom_range(0, 256)));
		end else if (r < 10) begin
			send_op(OP_W'($urandom_range(0, 7)), REG_W'($urandom),
				ID_W'($urandom_range(0, 256)), ID_W'($urandom_range(0, 256)));
		end else if (r < 25) begin
			send_op(c ? OP_MAP_FP : OP_MAP_INT, REG_W'($urandom), ID_W'($urandom_range(0, 256)),
				ID_W'($urandom_range(0, 256)));
		end else if ($urandom_range(0, 99) < alloc_bias || in_use[c].size() == 0) begin
			areg = ($urandom_range(0, 15) == 0) ? '0 : REG_W'($urandom_range(1, ARCH - 1));
			send_op(c ? OP_ALLOC_FP : OP_ALLOC_INT, areg, ID_W'($urandom_range(0, 256)),
				ID_W'($urandom_range(0, 256)));
			if (last_pred.success) begin
				t.areg = areg;
				t.new_id = last_pred.phys_id;
				t.old_id = last_pred.prior_phys;
				in_use[c].push_back(t);
			end
		end else begin
			// mostly youngest first, as a rollback would
			k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, in_use[c].size() - 1)
				: in_use[c].size() - 1;
			t = in_use[c][k];
			in_use[c].delete(k);
			send_op(c ? OP_FREE_FP : OP_FREE_INT, t.areg, t.new_id, t.old_id);
		end
	endtask

	task automatic random_phase(int n);
		int bias;
		int regime;
		bias = 25;
		regime = 0;
		for (int i = 0; i < n; i++) begin
			if (i == 3) begin
				// new totals apply here; frees straight after hit a full or fresh stack
				send_op(OP_FLUSH, '0, '0, '0);
				send_op(OP_FREE_INT, REG_W'($urandom_range(1, ARCH - 1)),
					ID_W'($urandom_range(1, 256)), ID_W'($urandom_range(0, 256)));
				send_op(OP_FREE_FP, REG_W'($urandom), ID_W'($urandom_range(1, 256)),
					ID_W'($urandom_range(0, 256)));
			end
			if (regime == 0) begin
				bias = (bias > 50) ? 25 : 85;
				regime = $urandom_range(20, 120);
			end
			regime--;
			random_op(bias);
		end
	endtask

	initial begin
		int int_totals [6];
		int fp_totals [6];
		int_totals = '{0, 256, 33, 32, 256, 90};
		fp_totals  = '{256, 0, 32, 33, 256, 45};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_op(OP_MAP_INT, 5'd0, 9'd0, 9'd0);
		send_op(OP_MAP_INT, 5'd31, 9'd0, 9'd0);
		send_op(OP_MAP_FP, 5'd0, 9'd0, 9'd0);
		send_op(OP_MAP_FP, 5'd31, 9'd0, 9'd0);
		send_op(OP_ALLOC_INT, 5'd0, 9'd0, 9'd0);
		send_op(OP_ALLOC_INT, 5'd31, 9'd0, 9'd0);
		send_op(OP_ALLOC_FP, 5'd0, 9'd0, 9'd0);
		send_op(OP_MAP_INT, 5'd31, 9'd0, 9'd0);
		send_op(OP_FREE_INT, 5'd0, 9'd200, 9'd7);
		send_op(OP_FREE_INT, 5'd5, 9'd0, 9'd9);
		send_op(OP_FREE_INT, 5'd31, 9'd256, 9'd256);
		send_op(OP_MAP_INT, 5'd31, 9'd0, 9'd0);
		send_op(OP_ALLOC_INT, 5'd31, 9'd0, 9'd0);
		send_op(OP_FREE_FP, 5'd0, 9'd128, 9'd1);
		send_op(OP_FREE_FP, 5'd3, 9'd1, 9'd4);
		send_op(OP_FREE_INT, 5'd31, 9'd255, 9'd511);
		send_op(OP_ALLOC_FP, 5'd3, 9'd511, 9'd511);
		send_op(OP_FLUSH, 5'd31, 9'd256, 9'd256);
		send_op(OP_MAP_FP, 5'd0, 9'd0, 9'd0);
		send_op(OP_MAP_INT, 5'd31, 9'd0, 9'd0);
		in_use[0].delete();
		in_use[1].delete();

		random_phase(250);
		for (int p = 0; p < 6; p++) begin
			wait_idle();
			write_reg(CFG_INT_TOTAL, ID_W'(int_totals[p]));
			write_reg(CFG_FP_TOTAL, ID_W'(fp_totals[p]));
			cfg_valid <= 1'b0;
			if (p == 1)
				hold_req = 1'b1;
			random_phase(290);
		end
		wait_idle();

		if (sb.failures == 0 && sb.expected.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/rrt_pkg.sv
hdl/rrt_rename_map.sv
hdl/rrt_free_stack.sv
hdl/register_rename_table.sv
hdl/rrt_checker.sv
verif/tb_register_rename_table.sv
